// ===== rtl/core/tdfa_pkg.sv =====
package tdfa_pkg;

    // operation codes carried on the input tuser
    localparam logic [1:0] OP_RUN   = 2'd0;
    localparam logic [1:0] OP_ALPHA = 2'd1;
    localparam logic [1:0] OP_TRANS = 2'd2;
    localparam logic [1:0] OP_FINAL = 2'd3;

    // verdict codes; reject kinds share the rejecting codes
    localparam logic [1:0] VD_ACCEPT   = 2'd0;
    localparam logic [1:0] VD_NONFINAL = 2'd1;
    localparam logic [1:0] VD_BADSYM   = 2'd2;
    localparam logic [1:0] VD_UNDEF    = 2'd3;
    localparam logic [1:0] REJ_NONE    = 2'd0;

    // configuration register indexes
    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_COUNT = 2'd1;

    localparam int OP_W       = 2;
    localparam int SYM_W      = 8;
    localparam int ST_W       = 4;
    localparam int POS_W      = 4;
    localparam int CNT_W      = 5;
    localparam int VD_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    // 4-bit index fields reach at most this many rows or columns
    localparam int FIELD_SPAN = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             found;
        logic [POS_W-1:0] pos;
        logic [ST_W-1:0]  st;
        logic [POS_W-1:0] si;
        logic [ST_W-1:0]  nx;
        logic             nv;
        logic             fin;
        logic             last;
    } t_work;

    typedef struct packed {
        logic [VD_W-1:0] verdict;
        logic [ST_W-1:0] end_state;
    } t_result;

endpackage

// ===== rtl/core/tdfa_ram.sv =====
module tdfa_ram #(
    parameter  int WIDTH = 4,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/tdfa_front.sv =====
module tdfa_front #(
    parameter int NUM_ROWS = 16,
    parameter int NUM_COLS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [tdfa_pkg::OP_W-1:0]     i_op,
    input  logic [tdfa_pkg::SYM_W-1:0]    i_symbol,
    input  logic [tdfa_pkg::ST_W-1:0]     i_state_index,
    input  logic [tdfa_pkg::POS_W-1:0]    i_symbol_index,
    input  logic [tdfa_pkg::ST_W-1:0]     i_next_state,
    input  logic                          i_next_valid,
    input  logic                          i_is_final,
    input  logic                          i_last,
    input  logic [tdfa_pkg::CNT_W-1:0]    i_symbol_count,
    input  logic                          i_full,
    output logic                          o_push,
    output tdfa_pkg::t_work               o_work
);
    import tdfa_pkg::*;

    logic [SYM_W-1:0] r_alpha [NUM_COLS];
    logic             accept;
    logic             found;
    logic [POS_W-1:0] pos;
    logic             st_ok;
    logic             si_ok;
    logic             nx_ok;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    assign st_ok = int'(i_state_index) < NUM_ROWS;
    assign si_ok = int'(i_symbol_index) < NUM_COLS;
    assign nx_ok = int'(i_next_state) < NUM_ROWS;

    // alphabet entries are matched in parallel; the highest match wins
    always_comb begin
        found = 1'b0;
        pos   = '0;
        for (int i = 0; i < NUM_COLS; i++) begin
            if ((CNT_W'(i) < i_symbol_count) && (r_alpha[i] == i_symbol)) begin
                found = 1'b1;
                pos   = POS_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_op == OP_ALPHA) && si_ok) begin
            r_alpha[i_symbol_index] <= i_symbol;
        end
    end

    // alphabet loads end here; out-of-range loads are dropped
    always_comb begin
        case (i_op)
            OP_RUN:   o_push = accept;
            OP_TRANS: o_push = accept && st_ok && si_ok;
            OP_FINAL: o_push = accept && st_ok;
            default:  o_push = 1'b0;
        endcase
    end

    always_comb begin
        o_work.op    = i_op;
        o_work.found = found;
        o_work.pos   = pos;
        o_work.st    = i_state_index;
        o_work.si    = i_symbol_index;
        o_work.nx    = i_next_state;
        o_work.nv    = i_next_valid && nx_ok;
        o_work.fin   = i_is_final;
        o_work.last  = i_last;
    end

endmodule

// ===== rtl/core/tdfa_queue.sv =====
module tdfa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tdfa_pkg::t_work i_work,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output tdfa_pkg::t_work o_head
);
    import tdfa_pkg::*;

    t_work             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;
    logic              do_pop;

    assign o_full  = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

endmodule

// ===== rtl/core/tdfa_back.sv =====
module tdfa_back #(
    parameter int NUM_ROWS = 16,
    parameter int NUM_COLS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  tdfa_pkg::t_work            i_head,
    output logic                       o_pop,
    input  logic [tdfa_pkg::ST_W-1:0]  i_start_state,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output tdfa_pkg::t_result          o_result
);
    import tdfa_pkg::*;

    localparam int DEPTH = NUM_ROWS * NUM_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(NUM_ROWS);

    // word state
    logic [ST_W-1:0]  r_cur_state, n_cur_state;
    logic [VD_W-1:0]  r_rej, n_rej;
    logic             r_in_word, n_in_word;
    logic             r_lookup, n_lookup;
    logic             r_fin_pend, n_fin_pend;
    logic             r_vbit;
    logic [DEPTH-1:0]    r_valid_bits;
    logic [NUM_ROWS-1:0] r_final;

    // two-entry result buffer
    t_result          r_ob [2];
    logic             r_ob_wr;
    logic             r_ob_rd;
    logic [1:0]       r_ob_cnt;

    logic [ST_W-1:0]  ram_rdata;
    logic [ST_W-1:0]  eff_state;
    logic [VD_W-1:0]  eff_rej;
    logic [ST_W-1:0]  st0;
    logic [VD_W-1:0]  rej0;
    logic             is_run;
    logic             is_trans;
    logic             is_final_ld;
    logic             take;
    logic [2:0]       occ;
    logic             room;
    logic [AW-1:0]    raddr;
    logic [AW-1:0]    waddr;
    logic             we;
    logic             fin_hit;
    t_result          res;

    // state after the lookup issued last cycle has landed
    assign eff_state = (r_lookup && r_vbit) ? ram_rdata : r_cur_state;
    assign eff_rej   = (r_lookup && !r_vbit) ? VD_UNDEF : r_rej;

    assign is_run      = i_head.op == OP_RUN;
    assign is_trans    = i_head.op == OP_TRANS;
    assign is_final_ld = i_head.op == OP_FINAL;

    // a last symbol may only leave the queue if its verdict will find room
    assign take = (r_ob_cnt != 2'd0) && i_out_ready;
    assign occ  = {1'b0, r_ob_cnt} + {2'b00, r_fin_pend} - {2'b00, take};
    assign room = occ <= 3'd1;
    assign o_pop = i_valid && (!(is_run && i_head.last) || room);

    assign st0  = r_in_word ? eff_state : i_start_state;
    assign rej0 = r_in_word ? eff_rej : REJ_NONE;

    assign raddr = AW'(int'(st0) * NUM_COLS + int'(i_head.pos));
    assign waddr = AW'(int'(i_head.st) * NUM_COLS + int'(i_head.si));
    assign we    = o_pop && is_trans;

    tdfa_ram #(
        .WIDTH (ST_W),
        .DEPTH (DEPTH)
    ) u_trans (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_head.nx),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_cur_state = eff_state;
        n_rej       = eff_rej;
        n_in_word   = r_in_word;
        n_lookup    = 1'b0;
        n_fin_pend  = 1'b0;
        if (o_pop && is_run) begin
            n_cur_state = st0;
            n_rej       = rej0;
            n_in_word   = !i_head.last;
            n_fin_pend  = i_head.last;
            if (rej0 == REJ_NONE) begin
                if (!i_head.found) begin
                    n_rej = VD_BADSYM;
                end else if (int'(st0) >= NUM_ROWS) begin
                    n_rej = VD_UNDEF;
                end else begin
                    n_lookup = 1'b1;
                end
            end
        end
    end

    assign fin_hit = (int'(eff_state) < NUM_ROWS) && r_final[eff_state[FW-1:0]];

    always_comb begin
        res.end_state = eff_state;
        if (eff_rej != REJ_NONE) begin
            res.verdict = eff_rej;
        end else if (fin_hit) begin
            res.verdict = VD_ACCEPT;
        end else begin
            res.verdict = VD_NONFINAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_state  <= '0;
            r_rej        <= REJ_NONE;
            r_in_word    <= 1'b0;
            r_lookup     <= 1'b0;
            r_fin_pend   <= 1'b0;
            r_valid_bits <= '0;
            r_final      <= '0;
            r_ob_wr      <= 1'b0;
            r_ob_rd      <= 1'b0;
            r_ob_cnt     <= 2'd0;
        end else begin
            r_cur_state <= n_cur_state;
            r_rej       <= n_rej;
            r_in_word   <= n_in_word;
            r_lookup    <= n_lookup;
            r_fin_pend  <= n_fin_pend;
            if (we) begin
                r_valid_bits[waddr] <= i_head.nv;
            end
            if (o_pop && is_final_ld) begin
                r_final[i_head.st[FW-1:0]] <= i_head.fin;
            end
            if (r_fin_pend) begin
                r_ob_wr <= ~r_ob_wr;
            end
            if (take) begin
                r_ob_rd <= ~r_ob_rd;
            end
            r_ob_cnt <= r_ob_cnt + {1'b0, r_fin_pend} - {1'b0, take};
        end
    end

    always_ff @(posedge i_clk) begin
        r_vbit <= r_valid_bits[raddr];
        if (r_fin_pend) begin
            r_ob[r_ob_wr] <= res;
        end
    end

    assign o_out_valid = r_ob_cnt != 2'd0;
    assign o_result    = r_ob[r_ob_rd];

    a_ob_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ob_cnt != 2'd3)
        else $error("result buffer overrun");

    a_lookup_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lookup |-> (r_rej == REJ_NONE))
        else $error("lookup issued for a rejected word");

    a_verdict_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_pend |=> (r_ob_cnt != 2'd0))
        else $error("verdict lost on its way to the output");

endmodule

// ===== rtl/core/table_driven_dfa_acceptor.sv =====
// A last symbol's verdict passes the work queue, the r_fin_pend register and the result buffer
// before m_axis offers it. Throughput: one beat per cycle while the queue is not full; the loop
// that sets it is the transition RAM read whose registered output feeds the next symbol's table address.
// Reset (i_rst_n low, synchronous): clears config, queue, word state, final marks and
// every transition valid bit at once; the alphabet holds nothing until written.
module table_driven_dfa_acceptor #(
    parameter int MAX_STATES  = 16,
    parameter int MAX_SYMBOLS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input beats
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] symbol, [11:8] state_index, [15:12] symbol_index, [19:16] next_state,
    // [20] next_valid, [21] is_final, [23:22] zero
    input  logic [tdfa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] operation
    input  logic [tdfa_pkg::OP_W-1:0]          s_axis_tuser,
    input  logic                               s_axis_tlast,
    // verdict beats
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [1:0] verdict, [5:2] end_state, [7:6] zero
    output logic [tdfa_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // register writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tdfa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tdfa_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import tdfa_pkg::*;

    // Index fields are 4 bits wide, so rows and columns beyond 16 can never be
    // loaded and are not built.
    localparam int NUM_ROWS = (MAX_STATES  < FIELD_SPAN) ? MAX_STATES  : FIELD_SPAN;
    localparam int NUM_COLS = (MAX_SYMBOLS < FIELD_SPAN) ? MAX_SYMBOLS : FIELD_SPAN;

    logic [ST_W-1:0]  r_start_state;
    logic [CNT_W-1:0] r_symbol_count;

    logic    q_full;
    logic    q_push;
    t_work   q_in;
    logic    q_valid;
    logic    q_pop;
    t_work   q_head;
    t_result result;

    // Configuration: always ready; written by the user only while the datapath is idle (not enforced).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state  <= '0;
            r_symbol_count <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START: r_start_state  <= i_cfg_data[ST_W-1:0];
                CFG_COUNT: r_symbol_count <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // Front: takes beats, keeps the alphabet, turns each symbol into an
    // alphabet position and drops loads that address nothing.
    tdfa_front #(
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS)
    ) u_front (
        .i_clk          (i_clk),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_op           (s_axis_tuser),
        .i_symbol       (s_axis_tdata[7:0]),
        .i_state_index  (s_axis_tdata[11:8]),
        .i_symbol_index (s_axis_tdata[15:12]),
        .i_next_state   (s_axis_tdata[19:16]),
        .i_next_valid   (s_axis_tdata[20]),
        .i_is_final     (s_axis_tdata[21]),
        .i_last         (s_axis_tlast),
        .i_symbol_count (r_symbol_count),
        .i_full         (q_full),
        .o_push         (q_push),
        .o_work         (q_in)
    );

    // Short work queue so a stalled output does not stop the front at once.
    tdfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_work  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // Back: transition RAM, final marks, word tracking and the verdict buffer.
    tdfa_back #(
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_head        (q_head),
        .o_pop         (q_pop),
        .i_start_state (r_start_state),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_result      (result)
    );

    assign m_axis_tdata = {2'b00, result.end_state, result.verdict};

endmodule
